### sv/obrs_pkg.sv
`default_nettype none
package obrs_pkg;

	// contrast ramp length limit (1..62)
	localparam int RampSteps = 32;
	localparam int StepW     = $clog2(RampSteps + 1);

	// shared divider: dividend covers |diff| * step index, divisor covers the step count
	localparam int DivsW = StepW;
	localparam int DivdW = 8 + StepW;
	localparam int CntW  = $clog2(DivdW);

	localparam int BlW = 10;  // brightness scale 0..1000

	// reciprocals for the two constant divisions, exact over their input ranges
	localparam int          BlRecipSh = 27;
	localparam logic [29:0] BlRecip   = 30'd554619000;  // 500 * ceil(2^27 / 121)
	localparam int          PhRecipSh = 24;
	localparam logic [17:0] PhRecip   = 18'd218114;     // 13 * ceil(2^24 / 1000)

	localparam logic [1:0] OpLevel  = 2'd0;
	localparam logic [1:0] OpOffset = 2'd1;
	localparam logic [1:0] OpInit   = 2'd2;

	localparam logic [7:0] CmdContrast  = 8'h81;
	localparam logic [7:0] CmdPrecharge = 8'hD9;
	localparam logic [7:0] CmdVcomh     = 8'hDB;

	localparam logic [7:0] LevelFloor    = 8'd13;
	localparam logic [7:0] LevelReset    = 8'd255;
	localparam logic [7:0] ContrastReset = 8'd255;
	localparam logic [7:0] ContrastFloor = 8'd5;
	localparam logic [7:0] ContrastCeil  = 8'd255;
	localparam logic [7:0] PrechargeInit = 8'hF1;
	localparam logic [7:0] VcomhInit     = 8'h40;
	localparam logic [7:0] VcomhLow      = 8'h00;
	localparam logic [7:0] VcomhMid      = 8'h20;
	localparam logic [7:0] VcomhHigh     = 8'h40;
	localparam logic [3:0] PhaseBase     = 4'd2;
	localparam logic [3:0] PrechargeLo   = 4'h1;

	localparam int BlScale   = 1000;
	localparam int BlSpan    = 242;
	localparam int BlVcomhLo = 250;
	localparam int BlVcomhMd = 500;
	localparam int PhaseSlope = 13;

	typedef struct packed {
		logic             start;
		logic [DivdW-1:0] dividend;
		logic [DivsW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DivdW-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

### sv/obrs_div.sv
`default_nettype none
// radix-2 restoring divider, one quotient bit per cycle
module obrs_div import obrs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic             busy_q;
	logic             done_q;
	logic [CntW-1:0]  cnt_q;
	logic [DivsW-1:0] rem_q;
	logic [DivdW-1:0] quo_q;
	logic [DivsW-1:0] dvs_q;

	logic [DivsW:0] shifted;
	logic [DivsW:0] trial;
	logic           fits;

	assign shifted = {rem_q, quo_q[DivdW-1]};
	assign fits    = shifted >= {1'b0, dvs_q};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && cnt_q == CntW'(DivdW - 1)) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CntW'(1);
			rem_q <= fits ? trial[DivsW-1:0] : shifted[DivsW-1:0];
			quo_q <= {quo_q[DivdW-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

### sv/oled_brightness_ramp_sequencer_unit.sv
`default_nettype none
// OLED brightness ramp sequencer. Opcode 0 sets a brightness level (floored to 13), opcode 1
// sets a signed contrast offset (applied times four), opcode 2 loads the current contrast and
// resets precharge/VCOMH/level to their power-on values without writing, opcode 3 is ignored.
// Levels and offsets map to VCOMH, precharge and contrast targets; the block then emits
// controller writes (command + argument) on the output channel, one per transfer, with the
// contrast walked in up to RampSteps interpolated steps. Dimming writes VCOMH and precharge
// before the ramp, brightening writes them after. No write is emitted when nothing changes.
// One item is worked at a time; in_stall is high from acceptance until the last write has
// been loaded into the output register. Level scaling and the precharge phase use constant
// reciprocal multiplies; every ramp step runs its interpolation divide through one shared
// bit-serial divider. A stalled output holds the sequencer in its write states. Init and
// opcode 3 finish on acceptance and never raise in_stall.
module oled_brightness_ramp_sequencer_unit import obrs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] level,
	input  wire logic signed [7:0] offset,
	input  wire logic [7:0] init_contrast,
	// output channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      command,
	output logic [7:0]      argument,
	output logic            end_of_transfer,
	output logic            wait_after,
	output logic            last
);

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_BL    = 4'd1;   // level scaling
	localparam logic [3:0] S_PH    = 4'd3;   // targets from the scaled level
	localparam logic [3:0] S_CMP   = 4'd5;   // compare targets, plan the sequence
	localparam logic [3:0] S_PRE1  = 4'd6;   // dimming: VCOMH
	localparam logic [3:0] S_PRE2  = 4'd7;   // dimming: precharge
	localparam logic [3:0] S_RDIV  = 4'd8;   // start ramp step divide
	localparam logic [3:0] S_RWAIT = 4'd9;
	localparam logic [3:0] S_REMIT = 4'd10;  // contrast step write
	localparam logic [3:0] S_POST1 = 4'd11;  // brightening: precharge
	localparam logic [3:0] S_POST2 = 4'd12;  // brightening: VCOMH

	logic [3:0] state_q;

	// display register shadows
	logic [7:0]        cur_con_q;
	logic [7:0]        cur_pre_q;
	logic [7:0]        cur_vcomh_q;
	logic [7:0]        lvl_q;
	logic signed [7:0] off_q;

	// per-item working registers
	logic [BlW-1:0]   bl_q;
	logic [7:0]       t_con_q;
	logic [7:0]       t_pre_q;
	logic [7:0]       t_vcomh_q;
	logic [7:0]       start_q;
	logic             neg_q;
	logic [7:0]       mag_q;
	logic [StepW-1:0] steps_q;
	logic [StepW-1:0] idx_q;
	logic [DivdW-1:0] acc_q;
	logic [7:0]       quo_q;
	logic             dim_q;
	logic             regs_q;

	// output register
	logic       out_valid_q;
	logic [7:0] cmd_q;
	logic [7:0] arg_q;
	logic       eot_q;
	logic       wait_q;
	logic       last_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	obrs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	logic in_xfer;
	logic out_free;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// divider request, issued once per ramp step
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = acc_q;
		div_req.divisor  = DivsW'(steps_q);
		unique case (state_q)
			S_RDIV: begin
				div_req.start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// bl = (level - floor) * 1000 / 242 and phase = bl * 13 / 1000 by reciprocal multiply
	logic [37:0] bl_prod;
	logic [27:0] ph_prod;

	assign bl_prod = 38'(lvl_q - LevelFloor) * 38'(BlRecip);
	assign ph_prod = 28'(bl_q) * 28'(PhRecip);

	// targets from the scaled level (valid in S_PH)
	logic signed [10:0] off_x4;
	logic signed [10:0] con_sum;
	logic [7:0]         t_con_d;
	logic [7:0]         t_vcomh_d;
	logic [7:0]         t_pre_d;

	assign off_x4  = {off_q[7], off_q, 2'b00};
	assign con_sum = $signed({3'b000, bl_q[BlW-1:2]}) + off_x4
		+ $signed({3'b000, ContrastFloor});

	always_comb begin
		if (con_sum < $signed({3'b000, ContrastFloor}))
			t_con_d = ContrastFloor;
		else if (con_sum > $signed({3'b000, ContrastCeil}))
			t_con_d = ContrastCeil;
		else
			t_con_d = con_sum[7:0];

		if (bl_q <= BlW'(BlVcomhLo))
			t_vcomh_d = VcomhLow;
		else if (bl_q <= BlW'(BlVcomhMd))
			t_vcomh_d = VcomhMid;
		else
			t_vcomh_d = VcomhHigh;

		t_pre_d = {PhaseBase + ph_prod[PhRecipSh +: 4], PrechargeLo};
	end

	// sequence plan from targets vs. current shadows
	logic             neg_d;
	logic [7:0]       mag_d;
	logic [StepW-1:0] steps_d;
	logic             regs_d;
	logic             change_d;

	always_comb begin
		neg_d  = t_con_q < cur_con_q;
		mag_d  = neg_d ? (cur_con_q - t_con_q) : (t_con_q - cur_con_q);
		regs_d = (t_pre_q != cur_pre_q) || (t_vcomh_q != cur_vcomh_q);
		change_d = regs_d || (t_con_q != cur_con_q);
		if ({1'b0, mag_d} > 9'(RampSteps))
			steps_d = StepW'(RampSteps);
		else if (mag_d == 8'd0)
			steps_d = StepW'(1);
		else
			steps_d = StepW'(mag_d);
	end

	// interpolated step: start +/- |diff| * i / steps (truncation toward zero)
	logic [7:0] ramp_val;
	logic       ramp_end;

	assign ramp_val = neg_q ? (start_q - quo_q) : (start_q + quo_q);
	assign ramp_end = (idx_q == steps_q);

	// write emission
	logic       emit;
	logic [7:0] emit_cmd;
	logic [7:0] emit_arg;
	logic       emit_eot;
	logic       emit_wait;
	logic       emit_last;

	always_comb begin
		emit      = 1'b0;
		emit_cmd  = CmdContrast;
		emit_arg  = ramp_val;
		emit_eot  = 1'b1;
		emit_wait = 1'b0;
		emit_last = 1'b0;
		unique case (state_q)
			S_PRE1: begin
				emit     = out_free;
				emit_cmd = CmdVcomh;
				emit_arg = t_vcomh_q;
				emit_eot = 1'b0;
			end
			S_PRE2: begin
				emit     = out_free;
				emit_cmd = CmdPrecharge;
				emit_arg = t_pre_q;
			end
			S_REMIT: begin
				emit      = out_free;
				emit_wait = !ramp_end;
				emit_last = ramp_end && !(regs_q && !dim_q);
			end
			S_POST1: begin
				emit     = out_free;
				emit_cmd = CmdPrecharge;
				emit_arg = t_pre_q;
				emit_eot = 1'b0;
			end
			S_POST2: begin
				emit      = out_free;
				emit_cmd  = CmdVcomh;
				emit_arg  = t_vcomh_q;
				emit_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer and shadow registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_con_q   <= ContrastReset;
			cur_pre_q   <= PrechargeInit;
			cur_vcomh_q <= VcomhInit;
			lvl_q       <= LevelReset;
			off_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						unique case (opcode)
							OpLevel: begin
								lvl_q   <= (level < LevelFloor) ? LevelFloor : level;
								state_q <= S_BL;
							end
							OpOffset: begin
								off_q   <= offset;
								state_q <= S_BL;
							end
							OpInit: begin
								cur_con_q   <= init_contrast;
								cur_pre_q   <= PrechargeInit;
								cur_vcomh_q <= VcomhInit;
								lvl_q       <= LevelReset;
							end
							default: begin
							end
						endcase
					end
				end
				S_BL:  state_q <= S_PH;
				S_PH:  state_q <= S_CMP;
				S_CMP: begin
					if (!change_d)
						state_q <= S_IDLE;
					else if (neg_d && regs_d)
						state_q <= S_PRE1;
					else
						state_q <= S_RDIV;
					cur_con_q   <= t_con_q;
					cur_pre_q   <= t_pre_q;
					cur_vcomh_q <= t_vcomh_q;
				end
				S_PRE1:  if (out_free) state_q <= S_PRE2;
				S_PRE2:  if (out_free) state_q <= S_RDIV;
				S_RDIV:  state_q <= S_RWAIT;
				S_RWAIT: if (div_rsp.done) state_q <= S_REMIT;
				S_REMIT: begin
					if (out_free) begin
						if (!ramp_end)
							state_q <= S_RDIV;
						else if (regs_q && !dim_q)
							state_q <= S_POST1;
						else
							state_q <= S_IDLE;
					end
				end
				S_POST1: if (out_free) state_q <= S_POST2;
				S_POST2: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_BL)
			bl_q <= bl_prod[BlRecipSh +: BlW];
		if (state_q == S_PH) begin
			t_con_q   <= t_con_d;
			t_pre_q   <= t_pre_d;
			t_vcomh_q <= t_vcomh_d;
		end
		if (state_q == S_CMP) begin
			start_q <= cur_con_q;
			neg_q   <= neg_d;
			mag_q   <= mag_d;
			steps_q <= steps_d;
			dim_q   <= neg_d;
			regs_q  <= regs_d;
			idx_q   <= StepW'(1);
			acc_q   <= DivdW'(mag_d);
		end
		if (state_q == S_RWAIT && div_rsp.done)
			quo_q <= div_rsp.quotient[7:0];
		if (state_q == S_REMIT && out_free) begin
			idx_q <= idx_q + StepW'(1);
			acc_q <= acc_q + DivdW'(mag_q);
		end
	end

	// output register: a finished write waits here while the sequencer moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cmd_q  <= emit_cmd;
			arg_q  <= emit_arg;
			eot_q  <= emit_eot;
			wait_q <= emit_wait;
			last_q <= emit_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign command         = cmd_q;
	assign argument        = arg_q;
	assign end_of_transfer = eot_q;
	assign wait_after      = wait_q;
	assign last            = last_q;

endmodule
`default_nettype wire

### sim/testbench.sv
`default_nettype none
module testbench import obrs_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// opcode 3 has no name in the package; the block drops it
	localparam logic [1:0] OpUnused = 2'd3;

	// cycles with no transfer on either channel before the run is declared hung
	localparam int StuckLimit = 5000;
	// quiet time after the last write, covers an item that still works on no writes
	localparam int DrainCycles = 200;
	localparam int RandomItems = 187;
	localparam int DirectedRows = 23;

	// one controller write as seen on the output channel
	typedef struct packed {
		logic [7:0] command;
		logic [7:0] argument;
		logic       end_of_transfer;
		logic       wait_after;
		logic       last;
	} write_t;

	// directed row; quiet marks rows that must produce no writes at all
	typedef struct {
		logic [1:0] op;
		int         lvl;
		int         off;
		int         ic;
		bit         quiet;
	} stim_t;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    in_valid      = 1'b0;
	logic                    in_stall;
	logic [1:0]              opcode        = OpLevel;
	logic [7:0]              level         = 8'd0;
	logic signed [7:0]       offset        = 8'sd0;
	logic [7:0]              init_contrast = 8'd0;
	logic                    out_valid;
	logic                    out_stall     = 1'b0;
	logic [7:0]              command;
	logic [7:0]              argument;
	logic                    end_of_transfer;
	logic                    wait_after;
	logic                    last;

	oled_brightness_ramp_sequencer_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.level           (level),
		.offset          (offset),
		.init_contrast   (init_contrast),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.command         (command),
		.argument        (argument),
		.end_of_transfer (end_of_transfer),
		.wait_after      (wait_after),
		.last            (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Display register shadow and write planner
	// ---------------------------------------------------------------
	logic [7:0]        disp_contrast;
	logic [7:0]        disp_precharge;
	logic [7:0]        disp_vcomh;
	logic [7:0]        lvl_stored;
	logic signed [7:0] off_stored;

	write_t planned[$];        // writes caused by the item just accepted
	write_t pending_writes[$]; // writes still owed by the block, oldest first
	int     failures = 0;

	function automatic void plan_push(logic [7:0] cmd, logic [7:0] arg, logic eot, logic wt);
		write_t w;
		w.command         = cmd;
		w.argument        = arg;
		w.end_of_transfer = eot;
		w.wait_after      = wt;
		w.last            = 1'b0;
		planned.push_back(w);
	endfunction

	// move the display from its current registers to the targets of the stored level/offset
	function automatic void retarget();
		int         bl, ph2, con, start, diff, mag, steps, v;
		logic [7:0] t_vcomh, t_pre, t_con;
		bit         dimming, regs_change;
		bl = (int'(lvl_stored) - int'(LevelFloor)) * BlScale / BlSpan;
		t_vcomh = (bl <= BlVcomhLo) ? VcomhLow : ((bl <= BlVcomhMd) ? VcomhMid : VcomhHigh);
		ph2 = int'(PhaseBase) + bl * PhaseSlope / BlScale;
		t_pre = {ph2[3:0], PrechargeLo};
		// contrast spans floor..ceiling linearly over the 0..1000 scale
		con = int'(ContrastFloor) + bl * (int'(ContrastCeil) - int'(ContrastFloor)) / BlScale
			+ int'(off_stored) * 4;
		if (con < int'(ContrastFloor))
			con = int'(ContrastFloor);
		if (con > int'(ContrastCeil))
			con = int'(ContrastCeil);
		t_con = con[7:0];
		if (t_con == disp_contrast && t_pre == disp_precharge && t_vcomh == disp_vcomh)
			return;
		start = int'(disp_contrast);
		diff = con - start;
		mag = (diff < 0) ? -diff : diff;
		steps = (mag > RampSteps) ? RampSteps : ((mag > 0) ? mag : 1);
		dimming = con < start;
		regs_change = (t_pre != disp_precharge) || (t_vcomh != disp_vcomh);
		// dimming: lower the drive before the contrast comes down
		if (dimming && regs_change) begin
			plan_push(CmdVcomh, t_vcomh, 1'b0, 1'b0);
			plan_push(CmdPrecharge, t_pre, 1'b1, 1'b0);
		end
		// SV division truncates toward zero, as the ramp interpolation requires
		for (int i = 1; i <= steps; i++) begin
			v = start + (diff * i) / steps;
			plan_push(CmdContrast, v[7:0], 1'b1, i < steps);
		end
		if (!dimming && regs_change) begin
			plan_push(CmdPrecharge, t_pre, 1'b0, 1'b0);
			plan_push(CmdVcomh, t_vcomh, 1'b1, 1'b0);
		end
		planned[planned.size() - 1].last = 1'b1;
		disp_contrast = t_con;
		disp_precharge = t_pre;
		disp_vcomh = t_vcomh;
	endfunction

	function automatic void plan_writes(logic [1:0] op, logic [7:0] lvl, logic signed [7:0] off,
		logic [7:0] ic);
		planned.delete();
		case (op)
			OpLevel: begin
				lvl_stored = (lvl < LevelFloor) ? LevelFloor : lvl;
				retarget();
			end
			OpOffset: begin
				off_stored = off;
				retarget();
			end
			OpInit: begin
				// loads the shadow only, nothing goes out
				disp_contrast = ic;
				disp_precharge = PrechargeInit;
				disp_vcomh = VcomhInit;
				lvl_stored = LevelReset;
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Input side: bursts of transfers separated by random gaps
	// ---------------------------------------------------------------
	int burst_left = 0;

	// called at a rising edge; returns at the edge where the transfer happens
	task automatic send_item(logic [1:0] op, logic [7:0] lvl, logic signed [7:0] off,
		logic [7:0] ic, bit quiet);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= op;
		level <= lvl;
		offset <= off;
		init_contrast <= ic;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		plan_writes(op, lvl, off, ic);
		// quiet rows carry their expectation in the table: nothing at all
		if (!quiet)
			foreach (planned[i])
				pending_writes.push_back(planned[i]);
	endtask

	// ---------------------------------------------------------------
	// Output side: stall pattern switching between calm, choppy and heavy stretches
	// ---------------------------------------------------------------
	int stall_style = 0;
	int style_left = 0;

	always @(posedge clk) begin
		if (style_left != 0) begin
			style_left <= style_left - 1;
		end else begin
			stall_style <= $urandom_range(0, 2);
			style_left <= $urandom_range(1, 40);
		end
		case (stall_style)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// every write transfer is checked against the oldest owed write
	always @(posedge clk) begin
		write_t got;
		write_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{command, argument, end_of_transfer, wait_after, last};
			if (pending_writes.size() == 0) begin
				$display("%0t: unexpected write: cmd %02h arg %02h eot %0d wait %0d last %0d",
					$time, got.command, got.argument, got.end_of_transfer, got.wait_after, got.last);
				failures++;
			end else begin
				want = pending_writes.pop_front();
				if (got !== want) begin
					$display("%0t: write mismatch: expected cmd %02h arg %02h eot %0d wait %0d last %0d",
						$time, want.command, want.argument, want.end_of_transfer, want.wait_after,
						want.last);
					$display("%0t:                 actual   cmd %02h arg %02h eot %0d wait %0d last %0d",
						$time, got.command, got.argument, got.end_of_transfer, got.wait_after, got.last);
					failures++;
				end
			end
		end
	end

	// hang detection: any transfer on either channel resets the count
	int stuck_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		wait (stuck_cycles >= StuckLimit);
		$display("%0t: no transfer for %0d cycles", $time, StuckLimit);
		$display("FAILED: results differ");
		$finish;
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	stim_t directed [DirectedRows] = '{
		'{OpLevel,  255,    0,   0, 1'b1}, // reset state already matches full level
		'{OpOffset,   0,    0,   0, 1'b1}, // zero offset, still no change
		'{OpUnused, 255,   -1, 255, 1'b1}, // unused opcode is dropped
		'{OpLevel,    0,    0,   0, 1'b0}, // dim to the floor, VCOMH/precharge first
		'{OpLevel,   12,    0,   0, 1'b1}, // floors to 13: same targets
		'{OpLevel,   13,    0,   0, 1'b1},
		'{OpLevel,   14,    0,   0, 1'b0}, // single contrast step up
		'{OpOffset,   0,  127,   0, 1'b0}, // clamps at the ceiling
		'{OpOffset,   0, -128,   0, 1'b0}, // clamps at the floor
		'{OpOffset,   0,   -1,   0, 1'b0},
		'{OpOffset,   0,    0,   0, 1'b0},
		'{OpLevel,  255,    0,   0, 1'b0}, // brighten, registers after the ramp
		'{OpInit,     0,    0,   0, 1'b1}, // init never writes
		'{OpLevel,  255,    0,   0, 1'b0}, // full ramp up from zero contrast
		'{OpInit,     0,    0, 255, 1'b1},
		'{OpLevel,  255,    0,   0, 1'b1}, // init state matches full level
		'{OpInit,     0,    0, 130, 1'b1},
		'{OpLevel,  134,    0,   0, 1'b0}, // contrast unchanged, VCOMH/precharge move
		'{OpLevel,   60,    0,   0, 1'b0},
		'{OpLevel,  200,    0,   0, 1'b0},
		'{OpOffset,   0,    3,   0, 1'b0},
		'{OpOffset,   0,   -3,   0, 1'b0},
		'{OpOffset,   0,    0,   0, 1'b0}
	};

	initial begin
		int         sent;
		int         pick;
		logic [1:0] op;
		logic [7:0] lvl;
		logic [7:0] off;
		logic [7:0] ic;

		disp_contrast = ContrastReset;
		disp_precharge = PrechargeInit;
		disp_vcomh = VcomhInit;
		lvl_stored = LevelReset;
		off_stored = 8'sd0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i].op, 8'(directed[i].lvl), 8'(directed[i].off),
				8'(directed[i].ic), directed[i].quiet);

		// mostly level/offset changes; offsets kept small most of the time so
		// the contrast lands inside the clamp range; some inits and dropped opcodes
		sent = 0;
		while (sent < RandomItems) begin
			pick = $urandom_range(0, 99);
			lvl = $urandom_range(0, 255);
			ic = $urandom_range(0, 255);
			off = ($urandom_range(0, 9) < 7) ? 8'($signed($urandom_range(0, 24)) - 12)
				: 8'($urandom_range(0, 255));
			if (pick < 50)
				op = OpLevel;
			else if (pick < 77)
				op = OpOffset;
			else if (pick < 92)
				op = OpInit;
			else
				op = OpUnused;
			send_item(op, lvl, off, ic, 1'b0);
			sent++;
		end
		in_valid <= 1'b0;

		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (failures == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
sv/obrs_pkg.sv
sv/obrs_div.sv
sv/oled_brightness_ramp_sequencer_unit.sv
sim/testbench.sv
